// File: sv/ggd_pkg.sv
// ggd_pkg: field widths, divider sizing, controller states and the
// command/status structs shared by the gregorian date normaliser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ggd_pkg;

    localparam int YEAR_IN_W   = 13;
    localparam int MONTH_IN_W  = 13;
    localparam int DAY_IN_W    = 21;
    localparam int YEAR_OUT_W  = 14;
    localparam int MONTH_OUT_W = 4;
    localparam int DAY_OUT_W   = 5;

    // shared constant divider
    localparam int DIV_W = 23;
    localparam int REM_W = 18;

    typedef enum logic [2:0] {
        DIV_MONTH,
        DIV_ERA,
        DIV_DAYS,
        DIV_CENT,
        DIV_YEAR
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M_START,
        ST_M_WAIT,
        ST_E_START,
        ST_E_WAIT,
        ST_COMPOSE,
        ST_Z_START,
        ST_Z_WAIT,
        ST_C_START,
        ST_C_WAIT,
        ST_Y_START,
        ST_Y_WAIT,
        ST_DOY,
        ST_FINISH
    } ggd_state_t;

    typedef struct packed {
        logic    capture_in;
        logic    div_start;
        div_op_t div_op;
        logic    take_month;
        logic    take_era;
        logic    compose;
        logic    take_days;
        logic    take_cent;
        logic    take_year;
        logic    calc_doy;
        logic    finish;
    } ggd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } ggd_sts_t;

endpackage

`default_nettype wire

// File: sv/ggd_if.sv
// ggd_req_if / ggd_rsp_if: valid/ready channels for the date normaliser
// depends on ggd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ggd_req_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ggd_pkg::YEAR_IN_W-1:0]   year_in;
    logic signed [ggd_pkg::MONTH_IN_W-1:0]  month_in;
    logic signed [ggd_pkg::DAY_IN_W-1:0]    day_in;

    modport source (output valid, output year_in, output month_in, output day_in,
                    input ready);
    modport sink   (input valid, input year_in, input month_in, input day_in,
                    output ready);
endinterface

interface ggd_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [ggd_pkg::YEAR_OUT_W-1:0] year_out;
    logic [ggd_pkg::MONTH_OUT_W-1:0]    month_out;
    logic [ggd_pkg::DAY_OUT_W-1:0]      day_out;

    modport source (output valid, output year_out, output month_out, output day_out,
                    input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    output ready);
endinterface

`default_nettype wire

// File: sv/ggd_div.sv
// ggd_div: division by one of the fixed calendar divisors through a
// rounded-up reciprocal multiply, quotient then remainder registered
// depends on ggd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ggd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ggd_pkg::div_op_t            op,
    input  logic [ggd_pkg::DIV_W-1:0]   dividend,
    output logic [ggd_pkg::DIV_W-1:0]   quotient,
    output logic [ggd_pkg::REM_W-1:0]   remainder,
    output logic                        done
);
    import ggd_pkg::*;

    localparam int RCP_W  = 24;
    localparam int PROD_W = DIV_W + RCP_W;

    localparam int D_MONTH = 12;
    localparam int D_ERA   = 400;
    localparam int D_DAYS  = 146097;
    localparam int D_CENT  = 1460;
    localparam int D_YEAR  = 365;

    // shift is DIV_W plus the divisor's bit length, exact for any dividend
    localparam int SH_MONTH = 27;
    localparam int SH_ERA   = 32;
    localparam int SH_DAYS  = 41;
    localparam int SH_CENT  = 34;
    localparam int SH_YEAR  = 32;

    localparam logic [RCP_W-1:0] RCP_MONTH =
        RCP_W'(((64'd1 << SH_MONTH) + 64'(D_MONTH - 1)) / 64'(D_MONTH));
    localparam logic [RCP_W-1:0] RCP_ERA =
        RCP_W'(((64'd1 << SH_ERA) + 64'(D_ERA - 1)) / 64'(D_ERA));
    localparam logic [RCP_W-1:0] RCP_DAYS =
        RCP_W'(((64'd1 << SH_DAYS) + 64'(D_DAYS - 1)) / 64'(D_DAYS));
    localparam logic [RCP_W-1:0] RCP_CENT =
        RCP_W'(((64'd1 << SH_CENT) + 64'(D_CENT - 1)) / 64'(D_CENT));
    localparam logic [RCP_W-1:0] RCP_YEAR =
        RCP_W'(((64'd1 << SH_YEAR) + 64'(D_YEAR - 1)) / 64'(D_YEAR));

    logic [DIV_W-1:0]  x_reg, x_next;
    div_op_t           op_reg, op_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              mul_pend_reg, mul_pend_next;
    logic              sub_pend_reg, sub_pend_next;
    logic              done_reg, done_next;
    logic [RCP_W-1:0]  rcp;
    logic [REM_W-1:0]  dsr;
    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  quo_est;
    logic [DIV_W-1:0]  qd;

    assign prod = PROD_W'(x_reg) * PROD_W'(rcp);
    assign qd   = quo_reg * DIV_W'(dsr);

    always_comb
    begin
        case (op_reg)
            DIV_MONTH:
            begin
                rcp     = RCP_MONTH;
                dsr     = REM_W'(D_MONTH);
                quo_est = DIV_W'(prod >> SH_MONTH);
            end
            DIV_ERA:
            begin
                rcp     = RCP_ERA;
                dsr     = REM_W'(D_ERA);
                quo_est = DIV_W'(prod >> SH_ERA);
            end
            DIV_DAYS:
            begin
                rcp     = RCP_DAYS;
                dsr     = REM_W'(D_DAYS);
                quo_est = DIV_W'(prod >> SH_DAYS);
            end
            DIV_CENT:
            begin
                rcp     = RCP_CENT;
                dsr     = REM_W'(D_CENT);
                quo_est = DIV_W'(prod >> SH_CENT);
            end
            DIV_YEAR:
            begin
                rcp     = RCP_YEAR;
                dsr     = REM_W'(D_YEAR);
                quo_est = DIV_W'(prod >> SH_YEAR);
            end
            default:
            begin
                rcp     = RCP_MONTH;
                dsr     = REM_W'(D_MONTH);
                quo_est = DIV_W'(prod >> SH_MONTH);
            end
        endcase
    end

    always_comb
    begin
        x_next        = x_reg;
        op_next       = op_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        mul_pend_next = 1'b0;
        sub_pend_next = mul_pend_reg;
        done_next     = done_reg || sub_pend_reg;
        if (start)
        begin
            x_next        = dividend;
            op_next       = op;
            mul_pend_next = 1'b1;
            sub_pend_next = 1'b0;
            done_next     = 1'b0;
        end
        else
        begin
            if (mul_pend_reg)
            begin
                quo_next = quo_est;
            end
            if (sub_pend_reg)
            begin
                rem_next = REM_W'(x_reg - qd);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            sub_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mul_pend_reg <= mul_pend_next;
            sub_pend_reg <= sub_pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        op_reg  <= op_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// File: sv/ggd_dp.sv
// ggd_dp: datapath of the date normaliser, month carry, day count and
// calendar split around the shared divider, plus the result register
// depends on ggd_pkg and ggd_div
`timescale 1ns / 1ps
`default_nettype none

module ggd_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ggd_pkg::ggd_cmd_t                       cmd,
    output ggd_pkg::ggd_sts_t                       sts,
    input  logic signed [ggd_pkg::YEAR_IN_W-1:0]    year_in,
    input  logic signed [ggd_pkg::MONTH_IN_W-1:0]   month_in,
    input  logic signed [ggd_pkg::DAY_IN_W-1:0]     day_in,
    input  logic                                    rsp_ready,
    output logic                                    rsp_valid,
    output logic signed [ggd_pkg::YEAR_OUT_W-1:0]   year_out,
    output logic [ggd_pkg::MONTH_OUT_W-1:0]         month_out,
    output logic [ggd_pkg::DAY_OUT_W-1:0]           day_out
);
    import ggd_pkg::*;

    localparam logic [13:0] MONTH_BIAS = 14'd4103;
    localparam logic [13:0] ERA_BIAS   = 14'd4800;
    localparam int          DAYS_ERA   = 146097;

    // day of the march-based year on which each month starts
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] centuries(input logic [8:0] yoe);
        logic [1:0] c;
        if (yoe >= 9'd300)
            c = 2'd3;
        else if (yoe >= 9'd200)
            c = 2'd2;
        else if (yoe >= 9'd100)
            c = 2'd1;
        else
            c = 2'd0;
        return c;
    endfunction

    function automatic logic [2:0] day_centuries(input logic [REM_W-1:0] doe);
        logic [2:0] c;
        if (doe >= REM_W'(146096))
            c = 3'd4;
        else if (doe >= REM_W'(109572))
            c = 3'd3;
        else if (doe >= REM_W'(73048))
            c = 3'd2;
        else if (doe >= REM_W'(36524))
            c = 3'd1;
        else
            c = 3'd0;
        return c;
    endfunction

    logic signed [YEAR_IN_W-1:0]  y_reg;
    logic signed [MONTH_IN_W-1:0] m_reg;
    logic signed [DAY_IN_W-1:0]   d_reg;
    logic signed [YEAR_OUT_W-1:0] yy_reg, yy_next;
    logic [3:0]                   mon0_reg;
    logic [4:0]                   ebias_reg;
    logic [8:0]                   yoe_reg;
    logic [DIV_W-1:0]             zb_reg, zb_next;
    logic signed [5:0]            era2_reg;
    logic [REM_W-1:0]             doe2_reg;
    logic [REM_W-1:0]             t_reg, t_next;
    logic [8:0]                   yoe2_reg;
    logic [8:0]                   doy_reg;
    logic signed [YEAR_OUT_W-1:0] ybase_reg, ybase_next;
    logic                         rsp_valid_reg;
    logic signed [YEAR_OUT_W-1:0] year_out_reg, year_out_next;
    logic [MONTH_OUT_W-1:0]       month_out_reg, month_out_next;
    logic [DAY_OUT_W-1:0]         day_out_reg, day_out_next;

    logic [DIV_W-1:0]             div_dividend;
    logic [DIV_W-1:0]             div_quo;
    logic [REM_W-1:0]             div_rem;
    logic                         div_done;
    logic [13:0]                  month_biased;
    logic [13:0]                  era_biased;
    logic signed [10:0]           carry;
    logic [3:0]                   mp_first;
    logic [REM_W-1:0]             doe_first;
    logic [DIV_W-1:0]             era_days;
    logic signed [DIV_W:0]        zsum;
    logic [REM_W-1:0]             doy_full;
    logic [3:0]                   mp_fin;
    logic [8:0]                   day_full;

    ggd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .op        (cmd.div_op),
        .dividend  (div_dividend),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign month_biased = 14'(m_reg) + MONTH_BIAS;
    assign era_biased   = 14'(yy_reg) + ERA_BIAS;

    always_comb
    begin
        case (cmd.div_op)
            DIV_MONTH: div_dividend = DIV_W'(month_biased);
            DIV_ERA:   div_dividend = DIV_W'(era_biased);
            DIV_DAYS:  div_dividend = zb_reg;
            DIV_CENT:  div_dividend = DIV_W'(doe2_reg);
            DIV_YEAR:  div_dividend = DIV_W'(t_reg);
            default:   div_dividend = zb_reg;
        endcase
    end

    // month carry into the year, january and february count with the year before
    assign carry   = 11'($signed({1'b0, div_quo[9:0]}) - 11'sd342);
    assign yy_next = YEAR_OUT_W'(y_reg) + YEAR_OUT_W'(carry)
                   - YEAR_OUT_W'(div_rem[3:0] < 4'd2);

    // day count of the date, the first of the month plus the day, biased by twenty eras
    assign mp_first  = (mon0_reg >= 4'd2) ? (mon0_reg - 4'd2) : (mon0_reg + 4'd10);
    assign doe_first = REM_W'(yoe_reg) * REM_W'(365) + REM_W'(yoe_reg >> 2)
                     - REM_W'(centuries(yoe_reg)) + REM_W'(month_start(mp_first));
    assign era_days  = DIV_W'(ebias_reg) * DIV_W'(DAYS_ERA);
    assign zsum      = $signed({1'b0, era_days}) + $signed({6'b0, doe_first})
                     + (DIV_W+1)'(d_reg) - 24'sd1;
    assign zb_next   = zsum[DIV_W-1:0];

    assign t_next = doe2_reg - REM_W'(div_quo[6:0]) + REM_W'(day_centuries(doe2_reg))
                  - REM_W'(doe2_reg == REM_W'(146096));

    assign doy_full   = doe2_reg - (REM_W'(yoe2_reg) * REM_W'(365)
                      + REM_W'(yoe2_reg >> 2) - REM_W'(centuries(yoe2_reg)));
    assign ybase_next = YEAR_OUT_W'(era2_reg) * YEAR_OUT_W'(400) + YEAR_OUT_W'(yoe2_reg);

    always_comb
    begin
        mp_fin = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy_reg >= month_start(4'(k)))
            begin
                mp_fin = 4'(k);
            end
        end
    end

    assign day_full       = doy_reg - month_start(mp_fin) + 9'd1;
    assign day_out_next   = day_full[DAY_OUT_W-1:0];
    assign month_out_next = (mp_fin < 4'd10) ? (mp_fin + 4'd3) : (mp_fin - 4'd9);
    assign year_out_next  = ybase_reg + YEAR_OUT_W'(mp_fin >= 4'd10);

    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            y_reg <= year_in;
            m_reg <= month_in;
            d_reg <= day_in;
        end
        if (cmd.take_month)
        begin
            yy_reg   <= yy_next;
            mon0_reg <= div_rem[3:0];
        end
        if (cmd.take_era)
        begin
            ebias_reg <= div_quo[4:0] + 5'd8;
            yoe_reg   <= div_rem[8:0];
        end
        if (cmd.compose)
        begin
            zb_reg <= zb_next;
        end
        if (cmd.take_days)
        begin
            era2_reg <= $signed(div_quo[5:0] - 6'd20);
            doe2_reg <= div_rem;
        end
        if (cmd.take_cent)
        begin
            t_reg <= t_next;
        end
        if (cmd.take_year)
        begin
            yoe2_reg <= div_quo[8:0];
        end
        if (cmd.calc_doy)
        begin
            doy_reg   <= doy_full[8:0];
            ybase_reg <= ybase_next;
        end
        if (cmd.finish)
        begin
            year_out_reg  <= year_out_next;
            month_out_reg <= month_out_next;
            day_out_reg   <= day_out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_busy = rsp_valid_reg && !rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign year_out  = year_out_reg;
    assign month_out = month_out_reg;
    assign day_out   = day_out_reg;

endmodule

`default_nettype wire

// File: sv/ggd_ctrl.sv
// ggd_ctrl: sequencer of the date normaliser, steps the datapath through
// its five divisions and the final split
// depends on ggd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ggd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ggd_pkg::ggd_sts_t sts,
    output ggd_pkg::ggd_cmd_t cmd
);
    import ggd_pkg::*;

    ggd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture_in = 1'b1;
                    state_next     = ST_M_START;
                end
            end
            ST_M_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_MONTH;
                state_next    = ST_M_WAIT;
            end
            ST_M_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.take_month = 1'b1;
                    state_next     = ST_E_START;
                end
            end
            ST_E_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_ERA;
                state_next    = ST_E_WAIT;
            end
            ST_E_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.take_era = 1'b1;
                    state_next   = ST_COMPOSE;
                end
            end
            ST_COMPOSE:
            begin
                cmd.compose = 1'b1;
                state_next  = ST_Z_START;
            end
            ST_Z_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_DAYS;
                state_next    = ST_Z_WAIT;
            end
            ST_Z_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.take_days = 1'b1;
                    state_next    = ST_C_START;
                end
            end
            ST_C_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_CENT;
                state_next    = ST_C_WAIT;
            end
            ST_C_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.take_cent = 1'b1;
                    state_next    = ST_Y_START;
                end
            end
            ST_Y_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_YEAR;
                state_next    = ST_Y_WAIT;
            end
            ST_Y_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.take_year = 1'b1;
                    state_next    = ST_DOY;
                end
            end
            ST_DOY:
            begin
                cmd.calc_doy = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/gregorian_date_normalizer.sv
// Gregorian date normaliser: takes a signed year, month and day in any range
// and returns the same day as a proleptic Gregorian date, month 1..12 and day
// valid for that month, year 0 existing. One word in gives one word out. A
// word is accepted only while the block is idle, so a new word is not taken
// until the last one has reached the finish step; the time from acceptance to
// a valid result is set by five divisions by calendar constants on a shared
// reciprocal divider, each a load, a quotient, a remainder and a collect step,
// plus the compose, day-of-year and finish steps. A result that is not taken
// holds the finish step until the output register frees, and the next request
// is taken while a result waits.
// depends on ggd_pkg, ggd_if, ggd_ctrl and ggd_dp
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_normalizer (
    input  logic       clk,
    input  logic       rst_n,
    ggd_req_if.sink    req,
    ggd_rsp_if.source  rsp
);
    import ggd_pkg::*;

    ggd_cmd_t cmd;
    ggd_sts_t sts;

    ggd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ggd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .year_in   (req.year_in),
        .month_in  (req.month_in),
        .day_in    (req.day_in),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .year_out  (rsp.year_out),
        .month_out (rsp.month_out),
        .day_out   (rsp.day_out)
    );

endmodule

`default_nettype wire

// File: sv/ggd_checker.sv
// ggd_checker: port-level checks of the date normaliser, bound to the top
// depends on ggd_pkg and gregorian_date_normalizer
`timescale 1ns / 1ps
`default_nettype none

module ggd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  req_valid,
    input logic                                  req_ready,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic signed [ggd_pkg::YEAR_OUT_W-1:0] year_out,
    input logic [ggd_pkg::MONTH_OUT_W-1:0]       month_out,
    input logic [ggd_pkg::DAY_OUT_W-1:0]         day_out
);
    import ggd_pkg::*;

    localparam logic [MONTH_OUT_W-1:0] FEB       = 4'd2;
    localparam logic [DAY_OUT_W-1:0]   FEB_MAX   = 5'd29;
    localparam logic [DAY_OUT_W-1:0]   SHORT_MAX = 5'd30;
    localparam logic [DAY_OUT_W-1:0]   LONG_MAX  = 5'd31;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(year_out) && $stable(month_out)
                                    && $stable(day_out))
        else $error("result word changed while stalled");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (month_out >= 4'd1) && (month_out <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (day_out >= 5'd1) && (day_out <= LONG_MAX)
            && !((month_out == FEB) && (day_out > FEB_MAX))
            && !(((month_out == 4'd4) || (month_out == 4'd6) || (month_out == 4'd9)
                  || (month_out == 4'd11)) && (day_out > SHORT_MAX)))
        else $error("day beyond end of month");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a word is in progress");

endmodule

bind gregorian_date_normalizer ggd_checker u_ggd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .year_out  (rsp.year_out),
    .month_out (rsp.month_out),
    .day_out   (rsp.day_out)
);

`default_nettype wire
